// ===== src/c2e_pkg.sv =====
// Shared types, constants and helper functions for the CMOS clock to epoch block.
// No dependencies; imported by every module of the block.
`default_nettype none

package c2e_pkg;

    localparam logic CFG_BCD_MODE     = 1'b0;
    localparam logic CFG_HOUR_24_MODE = 1'b1;

    localparam logic [11:0] EPOCH_YEAR         = 12'd1970;
    localparam logic [11:0] BASE_YEAR          = 12'd2000;
    localparam logic [31:0] SECS_PER_DAY       = 32'd86400;
    localparam logic [19:0] SECS_PER_HOUR      = 20'd3600;
    localparam logic [19:0] SECS_PER_MINUTE    = 20'd60;
    localparam logic [19:0] DAYS_PER_YEAR      = 20'd365;
    localparam logic [19:0] LEAPS_BEFORE_EPOCH = 20'd477;

    typedef struct packed {
        logic [7:0]  second;
        logic [7:0]  minute;
        logic [7:0]  hour;
        logic [7:0]  weekday;
        logic [7:0]  day;
        logic [7:0]  month;
        logic [11:0] year;
        logic        range_error;
    } c2e_snap_t;

    typedef struct packed {
        logic [7:0]  second;
        logic [7:0]  minute;
        logic [7:0]  hour;
        logic [7:0]  weekday;
        logic [7:0]  day;
        logic [7:0]  month;
        logic [11:0] year;
        logic [31:0] epoch;
        logic        range_error;
    } c2e_res_t;

    function automatic logic [7:0] bcd_decode(input logic [7:0] b, input logic bcd_en);
        logic [7:0] v;
        v = {4'b0000, b[7:4]} * 8'd10 + {4'b0000, b[3:0]};
        return bcd_en ? v : b;
    endfunction

    // days before the first of the month, non-leap year
    function automatic logic [8:0] cum_days(input logic [3:0] mon);
        logic [8:0] d;
        case (mon)
            4'd1:    d = 9'd0;
            4'd2:    d = 9'd31;
            4'd3:    d = 9'd59;
            4'd4:    d = 9'd90;
            4'd5:    d = 9'd120;
            4'd6:    d = 9'd151;
            4'd7:    d = 9'd181;
            4'd8:    d = 9'd212;
            4'd9:    d = 9'd243;
            4'd10:   d = 9'd273;
            4'd11:   d = 9'd304;
            4'd12:   d = 9'd334;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

    // valid for years 1900..2399
    function automatic logic is_leap(input logic [11:0] y);
        return (y[1:0] == 2'b00) && (y != 12'd1900) && (y != 12'd2100)
            && (y != 12'd2200) && (y != 12'd2300);
    endfunction

endpackage

`default_nettype wire

// ===== src/c2e_front.sv =====
// Front end: configuration registers, BCD decode, 12/24-hour fixup, year and clamping.
// Depends on c2e_pkg.
`default_nettype none

module c2e_front
    import c2e_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_index,
    input  wire logic        cfg_data,
    input  wire logic [63:0] raw,
    output c2e_snap_t        snap
);

    logic bcd_mode_reg;
    logic bcd_mode_next;
    logic hour_24_reg;
    logic hour_24_next;

    logic [7:0]  raw_h;
    logic [7:0]  h12;
    logic        pm;
    logic [7:0]  hour;
    logic [7:0]  day;
    logic [7:0]  mon;
    logic [7:0]  yr;
    logic [7:0]  cen;
    logic [11:0] base;
    logic        err;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        bcd_mode_next = bcd_mode_reg;
        hour_24_next  = hour_24_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_BCD_MODE:     bcd_mode_next = cfg_data;
                CFG_HOUR_24_MODE: hour_24_next  = cfg_data;
                default:          bcd_mode_next = bcd_mode_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bcd_mode_reg <= 1'b1;
            hour_24_reg  <= 1'b0;
        end
        else
        begin
            bcd_mode_reg <= bcd_mode_next;
            hour_24_reg  <= hour_24_next;
        end
    end

    always_comb
    begin
        raw_h = raw[23:16];
        pm    = raw_h[7];
        h12   = bcd_decode({1'b0, raw_h[6:0]}, bcd_mode_reg);
        if (hour_24_reg)
            hour = bcd_decode(raw_h, bcd_mode_reg);
        else if (pm && h12 != 8'd12)
            hour = h12 + 8'd12;
        else if (!pm && h12 == 8'd12)
            hour = 8'd0;
        else
            hour = h12;

        yr  = bcd_decode(raw[55:48], bcd_mode_reg);
        cen = bcd_decode(raw[63:56], bcd_mode_reg);
        if (cen == 8'd19)
            base = 12'd1900;
        else if (cen == 8'd21)
            base = 12'd2100;
        else
            base = BASE_YEAR;

        err = 1'b0;
        mon = bcd_decode(raw[47:40], bcd_mode_reg);
        if (mon == 8'd0)
        begin
            mon = 8'd1;
            err = 1'b1;
        end
        else if (mon > 8'd12)
        begin
            mon = 8'd12;
            err = 1'b1;
        end
        day = bcd_decode(raw[39:32], bcd_mode_reg);
        if (day == 8'd0)
        begin
            day = 8'd1;
            err = 1'b1;
        end

        snap.second      = bcd_decode(raw[7:0], bcd_mode_reg);
        snap.minute      = bcd_decode(raw[15:8], bcd_mode_reg);
        snap.hour        = hour;
        snap.weekday     = bcd_decode(raw[31:24], bcd_mode_reg);
        snap.day         = day;
        snap.month       = mon;
        snap.year        = base + {4'b0000, yr};
        snap.range_error = err;
    end

endmodule

`default_nettype wire

// ===== src/c2e_queue.sv =====
// Small register FIFO between the front end and the epoch pipeline.
// Depends on c2e_pkg.
`default_nettype none

module c2e_queue
    import c2e_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    input  wire c2e_snap_t  wr_data,
    output logic            full,
    input  wire logic       pop,
    output logic            not_empty,
    output c2e_snap_t       rd_data
);

    localparam int PTR_W = (DEPTH > 2) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    c2e_snap_t          mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               do_push;
    logic               do_pop;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign rd_data   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= wr_data;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count above depth");

    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0 || count_reg == CNT_W'(DEPTH)) |-> wr_ptr_reg == rd_ptr_reg)
        else $error("queue pointers disagree with count");

endmodule

`default_nettype wire

// ===== src/c2e_back.sv =====
// Back end: two-stage epoch pipeline (day count and time of day, then day seconds).
// Depends on c2e_pkg; stage two is the output register.
`default_nettype none

module c2e_back
    import c2e_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire c2e_snap_t  in_snap,
    output logic            out_valid,
    input  wire logic       out_ready,
    output c2e_res_t        out_res
);

    logic               s1_valid_reg;
    logic               s1_valid_next;
    c2e_snap_t          s1_snap_reg;
    logic signed [19:0] s1_days_reg;
    logic signed [19:0] s1_days_next;
    logic [19:0]        s1_tod_reg;
    logic [19:0]        s1_tod_next;
    logic               s2_valid_reg;
    logic               s2_valid_next;
    c2e_res_t           s2_res_reg;
    c2e_res_t           s2_res_next;

    logic               adv1;
    logic               adv2;
    logic [11:0]        prev_year;
    logic [4:0]         q100;
    logic [2:0]         q400;
    logic [9:0]         leaps;
    logic signed [13:0] yd;
    logic signed [19:0] yd20;
    logic [8:0]         cum;
    logic               leap_adj;
    logic [31:0]        days32;

    assign adv2     = !s2_valid_reg || out_ready;
    assign adv1     = !s1_valid_reg || adv2;
    assign in_ready = adv1;

    always_comb
    begin
        prev_year = in_snap.year - 12'd1;
        if (prev_year < 12'd1900)
            q100 = 5'd18;
        else if (prev_year < 12'd2000)
            q100 = 5'd19;
        else if (prev_year < 12'd2100)
            q100 = 5'd20;
        else if (prev_year < 12'd2200)
            q100 = 5'd21;
        else if (prev_year < 12'd2300)
            q100 = 5'd22;
        else
            q100 = 5'd23;
        q400  = (prev_year < 12'd2000) ? 3'd4 : 3'd5;
        leaps = prev_year[11:2] - {5'b00000, q100} + {7'b0000000, q400};

        yd       = $signed({2'b00, in_snap.year}) - $signed({2'b00, EPOCH_YEAR});
        yd20     = 20'(yd);
        cum      = cum_days(in_snap.month[3:0]);
        leap_adj = is_leap(in_snap.year) && (in_snap.month > 8'd2);

        s1_days_next = yd20 * $signed(DAYS_PER_YEAR)
                     + $signed({10'b0, leaps}) - $signed(LEAPS_BEFORE_EPOCH)
                     + $signed({11'b0, cum}) + $signed({19'b0, leap_adj})
                     + $signed({12'b0, in_snap.day}) - 20'sd1;
        s1_tod_next  = {12'b0, in_snap.hour} * SECS_PER_HOUR
                     + {12'b0, in_snap.minute} * SECS_PER_MINUTE
                     + {12'b0, in_snap.second};
        s1_valid_next = adv1 ? in_valid : s1_valid_reg;
    end

    always_comb
    begin
        days32                  = $unsigned(32'(s1_days_reg));
        s2_res_next.second      = s1_snap_reg.second;
        s2_res_next.minute      = s1_snap_reg.minute;
        s2_res_next.hour        = s1_snap_reg.hour;
        s2_res_next.weekday     = s1_snap_reg.weekday;
        s2_res_next.day         = s1_snap_reg.day;
        s2_res_next.month       = s1_snap_reg.month;
        s2_res_next.year        = s1_snap_reg.year;
        s2_res_next.range_error = s1_snap_reg.range_error;
        s2_res_next.epoch       = 32'(days32 * SECS_PER_DAY) + {12'b0, s1_tod_reg};
        s2_valid_next           = adv2 ? s1_valid_reg : s2_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1 && in_valid)
        begin
            s1_snap_reg <= in_snap;
            s1_days_reg <= s1_days_next;
            s1_tod_reg  <= s1_tod_next;
        end
        if (adv2 && s1_valid_reg)
            s2_res_reg <= s2_res_next;
    end

    assign out_valid = s2_valid_reg;
    assign out_res   = s2_res_reg;

    a_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg |-> (s2_res_reg.month >= 8'd1 && s2_res_reg.month <= 8'd12
                          && s2_res_reg.day != 8'd0))
        else $error("unclamped month or day reached output");

    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !adv1) |=> (s1_valid_reg && $stable(s1_days_reg)))
        else $error("stage one lost an item under stall");

endmodule

`default_nettype wire

// ===== src/cmos_rtc_to_epoch_top.sv =====
// Top level: CMOS clock snapshot to Unix seconds.
// Depends on c2e_pkg, c2e_front, c2e_queue, c2e_back.
//
// Usage:
//   s_* stream carries one snapshot of eight raw clock bytes per beat.
//   m_* stream returns one decoded result per snapshot, in order.
//   cfg_* writes bcd_mode (index 0) and hour_24_mode (index 1); always ready.
//   The user must write config only while no snapshot is in flight; the block does not enforce this.
// Timing:
//   The result of an accepted beat is registered in the queue, then in the
//   day-count stage, then in the day-seconds stage (the output register).
//   One snapshot per cycle sustained while m_tready is high; the limit is the single-item stages.
// Reset:
//   bcd_mode = 1, hour_24_mode = 0, queue and pipeline empty.
// Stall:
//   When m_tready is low the output register holds, the pipeline fills,
//   then the queue fills (QUEUE_DEPTH beats) and s_tready drops.
`default_nettype none

module cmos_rtc_to_epoch_top
    import c2e_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // raw_seconds, raw_minutes, raw_hours, raw_weekday, raw_day, raw_month,
    // raw_year, raw_century (8 bits each)
    input  wire logic [63:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // second_out, minute_out, hour_out, weekday_out, day_out, month_out (8 each),
    // year_out (12), epoch_seconds (32), 4 zero bits
    output logic [95:0]      m_tdata,
    // range_error
    output logic             m_tuser,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_index,
    input  wire logic        cfg_data
);

    c2e_snap_t front_snap;
    c2e_snap_t head_snap;
    c2e_res_t  res;
    logic      q_full;
    logic      q_not_empty;
    logic      back_ready;

    c2e_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .raw       (s_tdata),
        .snap      (front_snap)
    );

    c2e_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (s_tvalid),
        .wr_data   (front_snap),
        .full      (q_full),
        .pop       (back_ready),
        .not_empty (q_not_empty),
        .rd_data   (head_snap)
    );

    c2e_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (q_not_empty),
        .in_ready  (back_ready),
        .in_snap   (head_snap),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (res)
    );

    assign s_tready = !q_full;
    assign m_tdata  = {4'b0000, res.epoch, res.year, res.month, res.day,
                       res.weekday, res.hour, res.minute, res.second};
    assign m_tuser  = res.range_error;

endmodule

`default_nettype wire

// ===== sim/c2e_checker.sv =====
// Scoreboard for cmos_rtc_to_epoch_top: mirrors the config writes, predicts each snapshot's
// decoded fields and epoch seconds, and compares every result beat in order.
// Depends on c2e_pkg for the config indexes and the result struct.
module c2e_checker
    import c2e_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [63:0] s_tdata,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [95:0] m_tdata,
    input  wire logic        m_tuser,
    input  wire logic        cfg_valid,
    input  wire logic        cfg_ready,
    input  wire logic        cfg_index,
    input  wire logic        cfg_data,
    output int unsigned      mismatches,
    output int unsigned      outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    c2e_res_t expected_times[$];
    logic     bcd_q;
    logic     h24_q;

    function automatic logic [7:0] unbcd(input logic [7:0] b, input logic bcd);
        logic [7:0] tens;
        tens = 8'(b[7:4]) * 8'd10;
        return bcd ? 8'(tens + 8'(b[3:0])) : b;
    endfunction

    function automatic bit gregorian_leap(input longint y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function automatic longint leap_count(input longint n);
        return n / 4 - n / 100 + n / 400;
    endfunction

    function automatic c2e_res_t predict_epoch(input logic [63:0] raw, input logic bcd,
                                               input logic h24);
        c2e_res_t   r;
        logic [7:0] cen;
        logic [7:0] yr;
        logic [7:0] hraw;
        longint     yl;
        longint     days;
        longint     total;
        int         month_len[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
        r.second  = unbcd(raw[7:0], bcd);
        r.minute  = unbcd(raw[15:8], bcd);
        hraw      = raw[23:16];
        r.weekday = unbcd(raw[31:24], bcd);
        r.day     = unbcd(raw[39:32], bcd);
        r.month   = unbcd(raw[47:40], bcd);
        yr        = unbcd(raw[55:48], bcd);
        cen       = unbcd(raw[63:56], bcd);
        r.range_error = 1'b0;

        if (h24)
            r.hour = unbcd(hraw, bcd);
        else
        begin
            r.hour = unbcd({1'b0, hraw[6:0]}, bcd);
            if (hraw[7] && r.hour != 8'd12)
                r.hour = 8'(r.hour + 8'd12);
            else if (!hraw[7] && r.hour == 8'd12)
                r.hour = 8'd0;
        end

        if (cen >= 8'd19 && cen <= 8'd21)
            yl = longint'(cen) * 100 + longint'(yr);
        else
            yl = 2000 + longint'(yr);
        r.year = 12'(yl);

        if (r.month == 8'd0)
        begin
            r.month = 8'd1;
            r.range_error = 1'b1;
        end
        else if (r.month > 8'd12)
        begin
            r.month = 8'd12;
            r.range_error = 1'b1;
        end
        if (r.day == 8'd0)
        begin
            r.day = 8'd1;
            r.range_error = 1'b1;
        end

        days = 365 * (yl - 1970) + leap_count(yl - 1) - leap_count(1969);
        for (int m = 1; m < r.month; m++)
        begin
            days += month_len[m - 1];
            if (m == 2 && gregorian_leap(yl))
                days += 1;
        end
        days += longint'(r.day) - 1;
        total = days * 86400 + longint'(r.hour) * 3600 + longint'(r.minute) * 60
              + longint'(r.second);
        r.epoch = total[31:0];
        return r;
    endfunction

    task automatic check_field(input string name, input longint unsigned want_v,
                               input longint unsigned got_v, inout int unsigned bad);
        if (want_v != got_v)
        begin
            $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name,
                     want_v, got_v);
            bad++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        c2e_res_t    want;
        int unsigned bad;
        bad = 0;
        if (!rst_n)
        begin
            expected_times.delete();
            bcd_q       <= 1'b1;
            h24_q       <= 1'b0;
            mismatches  <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_BCD_MODE)
                    bcd_q <= cfg_data;
                else
                    h24_q <= cfg_data;
            end
            if (m_tvalid && m_tready)
            begin
                if (expected_times.size() == 0)
                begin
                    $display("%0t ns: unexpected result beat, expected none, actual %0h/%0b",
                             $time, m_tdata, m_tuser);
                    bad++;
                end
                else
                begin
                    want = expected_times.pop_front();
                    check_field("second_out", want.second, m_tdata[7:0], bad);
                    check_field("minute_out", want.minute, m_tdata[15:8], bad);
                    check_field("hour_out", want.hour, m_tdata[23:16], bad);
                    check_field("weekday_out", want.weekday, m_tdata[31:24], bad);
                    check_field("day_out", want.day, m_tdata[39:32], bad);
                    check_field("month_out", want.month, m_tdata[47:40], bad);
                    check_field("year_out", want.year, m_tdata[59:48], bad);
                    check_field("epoch_seconds", want.epoch, m_tdata[91:60], bad);
                    check_field("tdata pad", 0, m_tdata[95:92], bad);
                    check_field("range_error", want.range_error, m_tuser, bad);
                end
            end
            if (s_tvalid && s_tready)
                expected_times.push_back(predict_epoch(s_tdata, bcd_q, h24_q));
            outstanding <= expected_times.size();
            mismatches  <= mismatches + bad;
        end
    end

endmodule

// ===== sim/cmos_rtc_to_epoch_top_tb.sv =====
// Testbench top for cmos_rtc_to_epoch_top: clock, reset, config phases, snapshot stimulus
// with random idling on both streams, and the verdict. Depends on c2e_pkg and c2e_checker.
module cmos_rtc_to_epoch_top_tb
    import c2e_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic [63:0] s_tdata   = '0;
    logic        m_tready  = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_index = 1'b0;
    logic        cfg_data  = 1'b0;
    logic        quiet     = 1'b0;
    logic        s_tready;
    logic        m_tvalid;
    logic [95:0] m_tdata;
    logic        m_tuser;
    logic        cfg_ready;
    int unsigned mismatches;
    int unsigned outstanding;

    cmos_rtc_to_epoch_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    c2e_checker scoreboard (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
        m_tready <= quiet || ($urandom_range(0, 99) >= 31);

    initial
    begin
        #2ms;
        $display("cmos_rtc_to_epoch_top_tb: errors");
        $finish;
    end

    function automatic logic [63:0] snap(input logic [7:0] sec, input logic [7:0] mins,
                                         input logic [7:0] hr, input logic [7:0] wd,
                                         input logic [7:0] dy, input logic [7:0] mon,
                                         input logic [7:0] yr, input logic [7:0] cen);
        return {cen, yr, mon, dy, wd, hr, mins, sec};
    endfunction

    function automatic logic [7:0] enc(input int v, input logic bcd);
        return bcd ? {4'(v / 10), 4'(v % 10)} : 8'(v);
    endfunction

    // mostly plausible clock contents in the current encoding, some raw noise
    function automatic logic [63:0] make_snapshot(input logic bcd, input logic h24);
        logic [7:0] hr;
        logic [7:0] cen;
        if ($urandom_range(0, 99) < 25)
            return {$urandom, $urandom};
        if (h24)
            hr = enc($urandom_range(0, 23), bcd);
        else
            hr = enc($urandom_range(1, 12), bcd) | ($urandom_range(0, 1) ? 8'h80 : 8'h00);
        if ($urandom_range(0, 99) < 20)
            cen = enc($urandom_range(0, 99), bcd);
        else
            cen = enc($urandom_range(19, 21), bcd);
        return snap(enc($urandom_range(0, 59), bcd), enc($urandom_range(0, 59), bcd), hr,
                    enc($urandom_range(1, 7), bcd), enc($urandom_range(1, 31), bcd),
                    enc($urandom_range(1, 12), bcd), enc($urandom_range(0, 99), bcd), cen);
    endfunction

    // returns at the edge that accepted the beat, tvalid still high
    task automatic send_snapshot(input logic [63:0] raw);
        while (!quiet && $urandom_range(0, 99) < 31)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tdata  <= raw;
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic val);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic random_phase(input logic bcd, input logic h24, input int n,
                                input bit calm);
        write_reg(CFG_BCD_MODE, bcd);
        write_reg(CFG_HOUR_24_MODE, h24);
        for (int i = 0; i < n; i++)
        begin
            quiet <= calm && i >= 100 && i < 260;
            send_snapshot(make_snapshot(bcd, h24));
        end
        drain();
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_reg(CFG_BCD_MODE, 1'b1);
        write_reg(CFG_HOUR_24_MODE, 1'b0);
        send_snapshot(snap(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
        send_snapshot(snap(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
        send_snapshot(snap(8'h00, 8'h00, 8'h12, 8'h04, 8'h01, 8'h01, 8'h70, 8'h19));
        send_snapshot(snap(8'h59, 8'h59, 8'h92, 8'h01, 8'h15, 8'h06, 8'h24, 8'h20));
        send_snapshot(snap(8'h01, 8'h02, 8'h81, 8'h02, 8'h10, 8'h03, 8'h99, 8'h20));
        send_snapshot(snap(8'h30, 8'h30, 8'h8B, 8'h03, 8'h28, 8'h11, 8'h50, 8'h20));
        send_snapshot(snap(8'h10, 8'h20, 8'h05, 8'h05, 8'h20, 8'h13, 8'h10, 8'h20));
        send_snapshot(snap(8'h10, 8'h20, 8'h05, 8'h05, 8'h15, 8'h00, 8'h10, 8'h20));
        send_snapshot(snap(8'h10, 8'h20, 8'h05, 8'h05, 8'h00, 8'h07, 8'h10, 8'h20));
        send_snapshot(snap(8'h00, 8'h00, 8'h01, 8'h01, 8'h31, 8'h02, 8'h23, 8'h20));
        send_snapshot(snap(8'h00, 8'h00, 8'h06, 8'h02, 8'h29, 8'h02, 8'h00, 8'h20));
        send_snapshot(snap(8'h00, 8'h00, 8'h12, 8'h01, 8'h01, 8'h03, 8'h00, 8'h21));
        send_snapshot(snap(8'h59, 8'h59, 8'h91, 8'h03, 8'h31, 8'h12, 8'h69, 8'h19));
        send_snapshot(snap(8'h00, 8'h00, 8'h12, 8'h01, 8'h01, 8'h01, 8'h00, 8'h19));
        send_snapshot(snap(8'h00, 8'h00, 8'h01, 8'h01, 8'h01, 8'h01, 8'h45, 8'h18));
        send_snapshot(snap(8'h00, 8'h00, 8'h01, 8'h01, 8'h01, 8'h01, 8'h45, 8'h22));
        send_snapshot(snap(8'hAF, 8'hAF, 8'hAF, 8'hAF, 8'hAF, 8'hAF, 8'hAF, 8'hAF));
        send_snapshot(snap(8'h99, 8'h99, 8'h7F, 8'h07, 8'h01, 8'h01, 8'h30, 8'h20));
        send_snapshot(snap(8'h08, 8'h14, 8'h03, 8'h02, 8'h19, 8'h01, 8'h38, 8'h20));
        drain();

        write_reg(CFG_BCD_MODE, 1'b0);
        write_reg(CFG_HOUR_24_MODE, 1'b1);
        send_snapshot(snap(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
        send_snapshot(snap(8'hFF, 8'hFF, 8'hFF, 8'h07, 8'h1F, 8'h0C, 8'hFF, 8'd21));
        send_snapshot(snap(8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 8'h00, 8'd19));
        drain();

        random_phase(1'b1, 1'b0, 350, 1'b0);
        random_phase(1'b0, 1'b0, 350, 1'b1);
        random_phase(1'b1, 1'b1, 350, 1'b0);
        random_phase(1'b0, 1'b1, 350, 1'b0);

        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("cmos_rtc_to_epoch_top_tb: clean");
        else
            $display("cmos_rtc_to_epoch_top_tb: errors");
        $finish;
    end

endmodule
